// ===== rtl/core/gds_pkg.sv =====
// ----------------------------------------------------------------------------
// gds_pkg
// Shared constants, register codes and types of the grid divergence stencil.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int MAX_X     = 64;
    localparam int MAX_Y     = 64;
    localparam int DATA_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int FIELD_W = 32;
    localparam int SIZE_W  = 7;
    localparam int PLANE_W = 16;
    localparam int COEF_W  = 32;
    localparam int LANES   = 3;

    localparam int COL_W = $clog2(MAX_X);
    localparam int ROW_W = $clog2(MAX_Y);
    localparam int XS_W  = $clog2(MAX_X + 1);
    localparam int YS_W  = $clog2(MAX_Y + 1);
    localparam int CELLS = MAX_X * MAX_Y;
    localparam int IDX_W = $clog2(CELLS);

    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_INV_DX = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_INV_DY = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_INV_DZ = REG_IDX_W'(5);

    localparam logic [SIZE_W-1:0]  SIZE_XY_RST = SIZE_W'(64);
    localparam logic [PLANE_W-1:0] SIZE_Z_RST  = PLANE_W'(64);
    localparam logic [COEF_W-1:0]  COEF_RST    = COEF_W'(65536);

    localparam int MAG_W    = DATA_BITS + 1;
    localparam int PROD_W   = MAG_W + COEF_W;
    localparam int RND_W    = PROD_W - FRAC_BITS;
    localparam int CAP_BITS = 60;
    localparam int TMAG_W   = (RND_W < CAP_BITS + 1) ? RND_W : CAP_BITS + 1;
    localparam int EXT_W    = (RND_W > CAP_BITS + 1) ? RND_W : CAP_BITS + 1;
    localparam int TERM_W   = TMAG_W + 1;
    localparam int SUM_W    = TERM_W + 2;

    typedef struct packed {
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_y;
        logic [PLANE_W-1:0] size_z;
        logic [COEF_W-1:0]  inv_two_dx;
        logic [COEF_W-1:0]  inv_two_dy;
        logic [COEF_W-1:0]  inv_two_dz;
    } t_cfg;

    typedef struct packed {
        logic interior;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic [DATA_BITS-1:0] u_p;
        logic [DATA_BITS-1:0] u_m;
        logic [DATA_BITS-1:0] v_p;
        logic [DATA_BITS-1:0] v_m;
        logic [DATA_BITS-1:0] w_new;
        logic [DATA_BITS-1:0] w_old;
    } t_taps;

endpackage

// ===== rtl/core/gds_cfg.sv =====
// ----------------------------------------------------------------------------
// gds_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module gds_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gds_pkg::ADDR_W-1:0]  paddr,
    input  logic [gds_pkg::PDATA_W-1:0] pwdata,
    output logic [gds_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output gds_pkg::t_cfg               o_cfg
);

    gds_pkg::t_cfg                      r_cfg;
    logic [gds_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gds_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x     <= gds_pkg::SIZE_XY_RST;
            r_cfg.size_y     <= gds_pkg::SIZE_XY_RST;
            r_cfg.size_z     <= gds_pkg::SIZE_Z_RST;
            r_cfg.inv_two_dx <= gds_pkg::COEF_RST;
            r_cfg.inv_two_dy <= gds_pkg::COEF_RST;
            r_cfg.inv_two_dz <= gds_pkg::COEF_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                gds_pkg::REG_SIZE_X: begin
                    r_cfg.size_x <= pwdata[gds_pkg::SIZE_W-1:0];
                end
                gds_pkg::REG_SIZE_Y: begin
                    r_cfg.size_y <= pwdata[gds_pkg::SIZE_W-1:0];
                end
                gds_pkg::REG_SIZE_Z: begin
                    r_cfg.size_z <= pwdata[gds_pkg::PLANE_W-1:0];
                end
                gds_pkg::REG_INV_DX: begin
                    r_cfg.inv_two_dx <= pwdata[gds_pkg::COEF_W-1:0];
                end
                gds_pkg::REG_INV_DY: begin
                    r_cfg.inv_two_dy <= pwdata[gds_pkg::COEF_W-1:0];
                end
                gds_pkg::REG_INV_DZ: begin
                    r_cfg.inv_two_dz <= pwdata[gds_pkg::COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gds_pkg::REG_SIZE_X: prdata = gds_pkg::PDATA_W'(r_cfg.size_x);
            gds_pkg::REG_SIZE_Y: prdata = gds_pkg::PDATA_W'(r_cfg.size_y);
            gds_pkg::REG_SIZE_Z: prdata = gds_pkg::PDATA_W'(r_cfg.size_z);
            gds_pkg::REG_INV_DX: prdata = gds_pkg::PDATA_W'(r_cfg.inv_two_dx);
            gds_pkg::REG_INV_DY: prdata = gds_pkg::PDATA_W'(r_cfg.inv_two_dy);
            gds_pkg::REG_INV_DZ: prdata = gds_pkg::PDATA_W'(r_cfg.inv_two_dz);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/gds_store.sv =====
// ----------------------------------------------------------------------------
// gds_store
// Raster counters and plane stores; reads the stencil taps of each item.
// ----------------------------------------------------------------------------
module gds_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gds_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [gds_pkg::FIELD_W-1:0]   i_vel_x,
    input  logic [gds_pkg::FIELD_W-1:0]   i_vel_y,
    input  logic [gds_pkg::FIELD_W-1:0]   i_vel_z,
    output logic                          o_a_valid,
    input  logic                          i_a_stall,
    output gds_pkg::t_taps                o_taps,
    output gds_pkg::t_ctl                 o_ctl
);

    localparam int BADDR_W = gds_pkg::IDX_W + 1;
    localparam int BANK_D  = 2 ** BADDR_W;
    localparam int DW      = gds_pkg::DATA_BITS;

    logic [DW-1:0] r_u_mem  [BANK_D];
    logic [DW-1:0] r_v_mem  [BANK_D];
    logic [DW-1:0] r_w_mem  [BANK_D];
    logic [DW-1:0] r_oz_mem [gds_pkg::CELLS];

    logic [gds_pkg::COL_W-1:0]   r_col;
    logic [gds_pkg::ROW_W-1:0]   r_row;
    logic [gds_pkg::PLANE_W-1:0] r_plane;

    logic                        r_a_valid;
    gds_pkg::t_ctl               r_ctl;
    logic [DW-1:0]               r_u_p;
    logic [DW-1:0]               r_u_m;
    logic [DW-1:0]               r_v_p;
    logic [DW-1:0]               r_v_m;
    logic [DW-1:0]               r_w_new;
    logic [DW-1:0]               r_w_prv;
    logic [DW-1:0]               r_z_old;
    logic                        r_oz_we;
    logic [gds_pkg::IDX_W-1:0]   r_oz_addr;

    logic [gds_pkg::XS_W-1:0]    sx;
    logic [gds_pkg::YS_W-1:0]    sy;
    logic [gds_pkg::PLANE_W-1:0] sz;
    logic [gds_pkg::XS_W-1:0]    col_p1;
    logic [gds_pkg::YS_W-1:0]    row_p1;
    logic [gds_pkg::PLANE_W:0]   plane_p1;
    logic                        end_row;
    logic                        end_plane;
    logic                        end_grid;
    logic                        emit;
    logic                        interior;
    logic                        accept;
    logic [gds_pkg::IDX_W-1:0]   idx;
    logic                        cur;
    logic                        prv;

    always_comb begin
        if (i_cfg.size_x < gds_pkg::SIZE_W'(3)) begin
            sx = gds_pkg::XS_W'(3);
        end else if (int'(i_cfg.size_x) > gds_pkg::MAX_X) begin
            sx = gds_pkg::XS_W'(gds_pkg::MAX_X);
        end else begin
            sx = gds_pkg::XS_W'(i_cfg.size_x);
        end
        if (i_cfg.size_y < gds_pkg::SIZE_W'(3)) begin
            sy = gds_pkg::YS_W'(3);
        end else if (int'(i_cfg.size_y) > gds_pkg::MAX_Y) begin
            sy = gds_pkg::YS_W'(gds_pkg::MAX_Y);
        end else begin
            sy = gds_pkg::YS_W'(i_cfg.size_y);
        end
        if (i_cfg.size_z < gds_pkg::PLANE_W'(3)) begin
            sz = gds_pkg::PLANE_W'(3);
        end else begin
            sz = i_cfg.size_z;
        end
    end

    assign col_p1    = gds_pkg::XS_W'(r_col) + gds_pkg::XS_W'(1);
    assign row_p1    = gds_pkg::YS_W'(r_row) + gds_pkg::YS_W'(1);
    assign plane_p1  = {1'b0, r_plane} + (gds_pkg::PLANE_W + 1)'(1);
    assign end_row   = col_p1 >= sx;
    assign end_plane = end_row && (row_p1 >= sy);
    assign end_grid  = end_plane && (plane_p1 >= {1'b0, sz});
    assign emit      = r_plane != '0;
    assign interior  = (r_plane >= gds_pkg::PLANE_W'(2)) && (r_col != '0) && (col_p1 < sx)
                       && (r_row != '0) && (row_p1 < sy);

    assign idx = gds_pkg::IDX_W'(r_row) * gds_pkg::IDX_W'(gds_pkg::MAX_X)
                 + gds_pkg::IDX_W'(r_col);
    assign cur = r_plane[0];
    assign prv = ~r_plane[0];

    assign o_stall = r_a_valid && i_a_stall;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else if (accept) begin
            if (end_grid) begin
                r_col   <= '0;
                r_row   <= '0;
                r_plane <= '0;
            end else if (end_plane) begin
                r_col   <= '0;
                r_row   <= '0;
                r_plane <= plane_p1[gds_pkg::PLANE_W-1:0];
            end else if (end_row) begin
                r_col <= '0;
                r_row <= row_p1[gds_pkg::ROW_W-1:0];
            end else begin
                r_col <= col_p1[gds_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_oz_we   <= 1'b0;
        end else begin
            r_oz_we <= accept && emit;
            if (accept) begin
                r_a_valid <= emit;
            end else if (!i_a_stall) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_u_mem[{cur, idx}] <= DW'(i_vel_x);
            r_v_mem[{cur, idx}] <= DW'(i_vel_y);
            r_w_mem[{cur, idx}] <= DW'(i_vel_z);
            r_u_p   <= r_u_mem[{prv, idx + gds_pkg::IDX_W'(1)}];
            r_u_m   <= r_u_mem[{prv, idx - gds_pkg::IDX_W'(1)}];
            r_v_p   <= r_v_mem[{prv, idx + gds_pkg::IDX_W'(gds_pkg::MAX_X)}];
            r_v_m   <= r_v_mem[{prv, idx - gds_pkg::IDX_W'(gds_pkg::MAX_X)}];
            r_w_prv <= r_w_mem[{prv, idx}];
            r_w_new <= DW'(i_vel_z);
            r_ctl.interior <= interior;
            r_ctl.last     <= end_grid;
            r_oz_addr      <= idx;
        end
    end

    // The older plane store is written in the cycle after its item is accepted, so a
    // read of the same cell in that cycle takes the value in flight.
    always_ff @(posedge i_clk) begin
        if (r_oz_we) begin
            r_oz_mem[r_oz_addr] <= r_w_prv;
        end
        if (accept) begin
            if (r_oz_we && (r_oz_addr == idx)) begin
                r_z_old <= r_w_prv;
            end else begin
                r_z_old <= r_oz_mem[idx];
            end
        end
    end

    assign o_a_valid    = r_a_valid;
    assign o_ctl        = r_ctl;
    assign o_taps.u_p   = r_u_p;
    assign o_taps.u_m   = r_u_m;
    assign o_taps.v_p   = r_v_p;
    assign o_taps.v_m   = r_v_m;
    assign o_taps.w_new = r_w_new;
    assign o_taps.w_old = r_z_old;

endmodule

// ===== rtl/core/gds_arith.sv =====
// ----------------------------------------------------------------------------
// gds_arith
// Difference, scaling, rounding and saturating sum of the three stencil terms.
// ----------------------------------------------------------------------------
module gds_arith (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gds_pkg::t_cfg                 i_cfg,
    input  logic                          i_a_valid,
    output logic                          o_a_stall,
    input  gds_pkg::t_taps                i_taps,
    input  gds_pkg::t_ctl                 i_ctl,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gds_pkg::FIELD_W-1:0]   o_div_value,
    output logic                          o_overflow,
    output logic                          o_last_cell
);

    localparam int DW     = gds_pkg::DATA_BITS;
    localparam int MAG_W  = gds_pkg::MAG_W;
    localparam int PROD_W = gds_pkg::PROD_W;
    localparam int EXT_W  = gds_pkg::EXT_W;
    localparam int TMAG_W = gds_pkg::TMAG_W;
    localparam int TERM_W = gds_pkg::TERM_W;
    localparam int SUM_W  = gds_pkg::SUM_W;
    localparam int NL     = gds_pkg::LANES;

    localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << (gds_pkg::FRAC_BITS - 1);
    localparam logic [EXT_W-1:0]  CAP_V = EXT_W'(1) << gds_pkg::CAP_BITS;
    localparam logic signed [SUM_W-1:0] DMAX =
        {{(SUM_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;

    logic [DW-1:0]                 plus  [NL];
    logic [DW-1:0]                 minus [NL];
    logic [gds_pkg::COEF_W-1:0]    coef  [NL];
    logic [MAG_W-1:0]              diff  [NL];
    logic [MAG_W-1:0]              n_mag [NL];
    logic [PROD_W-1:0]             rnd_full [NL];
    logic [EXT_W-1:0]              rnd_ext  [NL];
    logic [TMAG_W-1:0]             tmag     [NL];
    logic signed [TERM_W-1:0]      n_term   [NL];
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-1:0]       sat;
    logic                          ovf;

    logic                          r_b_valid;
    logic [MAG_W-1:0]              r_b_mag [NL];
    logic [NL-1:0]                 r_b_neg;
    gds_pkg::t_ctl                 r_b_ctl;
    logic                          r_c_valid;
    logic [PROD_W-1:0]             r_c_prod [NL];
    logic [NL-1:0]                 r_c_neg;
    gds_pkg::t_ctl                 r_c_ctl;
    logic                          r_d_valid;
    logic signed [TERM_W-1:0]      r_d_term [NL];
    gds_pkg::t_ctl                 r_d_ctl;
    logic                          r_e_valid;
    logic [gds_pkg::FIELD_W-1:0]   r_div;
    logic                          r_ovf;
    logic                          r_last;

    logic                          e_free;
    logic                          d_free;
    logic                          c_free;
    logic                          b_free;

    assign e_free    = !r_e_valid || !i_stall;
    assign d_free    = !r_d_valid || e_free;
    assign c_free    = !r_c_valid || d_free;
    assign b_free    = !r_b_valid || c_free;
    assign o_a_stall = !b_free;

    always_comb begin
        plus[0]  = i_taps.u_p;
        minus[0] = i_taps.u_m;
        plus[1]  = i_taps.v_p;
        minus[1] = i_taps.v_m;
        plus[2]  = i_taps.w_new;
        minus[2] = i_taps.w_old;
        coef[0]  = i_cfg.inv_two_dx;
        coef[1]  = i_cfg.inv_two_dy;
        coef[2]  = i_cfg.inv_two_dz;
        for (int k = 0; k < NL; k++) begin
            diff[k]  = {plus[k][DW-1], plus[k]} - {minus[k][DW-1], minus[k]};
            n_mag[k] = diff[k][MAG_W-1] ? (MAG_W'(0) - diff[k]) : diff[k];
            rnd_full[k] = r_c_prod[k] + HALF;
            rnd_ext[k]  = EXT_W'(rnd_full[k][PROD_W-1:gds_pkg::FRAC_BITS]);
            if (rnd_ext[k] > CAP_V) begin
                rnd_ext[k] = CAP_V;
            end
            tmag[k] = TMAG_W'(rnd_ext[k]);
            if (r_c_neg[k]) begin
                n_term[k] = TERM_W'(0) - {1'b0, tmag[k]};
            end else begin
                n_term[k] = {1'b0, tmag[k]};
            end
        end
    end

    always_comb begin
        sum = SUM_W'(r_d_term[0]) + SUM_W'(r_d_term[1]) + SUM_W'(r_d_term[2]);
        ovf = 1'b0;
        sat = sum;
        if (sum > DMAX) begin
            sat = DMAX;
            ovf = 1'b1;
        end else if (sum < DMIN) begin
            sat = DMIN;
            ovf = 1'b1;
        end
        if (!r_d_ctl.interior) begin
            sat = '0;
            ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_valid <= i_a_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (d_free) begin
                r_d_valid <= r_c_valid;
            end
            if (e_free) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && i_a_valid) begin
            for (int k = 0; k < NL; k++) begin
                r_b_mag[k] <= n_mag[k];
                r_b_neg[k] <= diff[k][MAG_W-1];
            end
            r_b_ctl <= i_ctl;
        end
        if (c_free && r_b_valid) begin
            for (int k = 0; k < NL; k++) begin
                r_c_prod[k] <= PROD_W'(r_b_mag[k]) * PROD_W'(coef[k]);
            end
            r_c_neg <= r_b_neg;
            r_c_ctl <= r_b_ctl;
        end
        if (d_free && r_c_valid) begin
            for (int k = 0; k < NL; k++) begin
                r_d_term[k] <= n_term[k];
            end
            r_d_ctl <= r_c_ctl;
        end
        if (e_free && r_d_valid) begin
            r_div  <= gds_pkg::FIELD_W'(sat);
            r_ovf  <= ovf;
            r_last <= r_d_ctl.last;
        end
    end

    assign o_valid     = r_e_valid;
    assign o_div_value = r_div;
    assign o_overflow  = r_ovf;
    assign o_last_cell = r_last;

endmodule

// ===== rtl/core/grid_divergence_stencil.sv =====
// ----------------------------------------------------------------------------
// grid_divergence_stencil
// Streaming central-difference divergence of a 3-D velocity grid.
// ----------------------------------------------------------------------------
// Velocity items arrive one cell at a time in raster order (x fastest, then y,
// then z) and one item is accepted in every cycle in which o_stall is low. Each
// item of plane k (k at least 1) yields one result: the divergence of the same
// cell in plane k-1, so results trail the input by one plane and plane 0 yields
// nothing. A result passes through the registered plane-store reads, the
// difference stage, the 33 by 32 bit multipliers, the rounding stage and the
// saturating sum, the last of which is the result register. Boundary cells
// and all results for the cells of plane 0 are zero, and the last result of a
// grid is marked by last_cell. The plane stores need no clearing after reset.
// ----------------------------------------------------------------------------
module grid_divergence_stencil (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [gds_pkg::FIELD_W-1:0] i_vel_x,
    input  logic signed [gds_pkg::FIELD_W-1:0] i_vel_y,
    input  logic signed [gds_pkg::FIELD_W-1:0] i_vel_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [gds_pkg::FIELD_W-1:0] o_div_value,
    output logic                             o_overflow,
    output logic                             o_last_cell,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gds_pkg::ADDR_W-1:0]       paddr,
    input  logic [gds_pkg::PDATA_W-1:0]      pwdata,
    output logic [gds_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    gds_pkg::t_cfg                 cfg;
    gds_pkg::t_taps                taps;
    gds_pkg::t_ctl                 ctl;
    logic                          a_valid;
    logic                          a_stall;
    logic [gds_pkg::FIELD_W-1:0]   div_value;

    gds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gds_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_vel_x   (i_vel_x),
        .i_vel_y   (i_vel_y),
        .i_vel_z   (i_vel_z),
        .o_a_valid (a_valid),
        .i_a_stall (a_stall),
        .o_taps    (taps),
        .o_ctl     (ctl)
    );

    gds_arith u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_a_valid   (a_valid),
        .o_a_stall   (a_stall),
        .i_taps      (taps),
        .i_ctl       (ctl),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_div_value (div_value),
        .o_overflow  (o_overflow),
        .o_last_cell (o_last_cell)
    );

    assign o_div_value = signed'(div_value);

endmodule

// ===== tb/grid_divergence_stencil_tb.sv =====
// ----------------------------------------------------------------------------
// grid_divergence_stencil_tb
// Self-checking testbench for the streaming 3-D divergence stencil.
// ----------------------------------------------------------------------------
// Velocity items are streamed grid by grid through the valid/stall input
// channel. A scoreboard object keeps its own copy of the plane stores,
// counters and registers, predicts each divergence result as items are
// accepted and compares every returned result field by field, in order. The
// run opens with a tiny saturating grid and then covers a mid-grid shrink
// from the largest sizes, random small grids with random spacing
// coefficients, random idling on both channels and one long output
// hold-off. A watchdog ends the run if no handshake happens for too long.
// ----------------------------------------------------------------------------
module grid_divergence_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_SHARE  = 310;
    localparam int SEND_IDLE [3] = '{30, 83, 0};
    localparam int RECV_IDLE [3] = '{83, 30, 0};

    localparam logic [gds_pkg::REG_IDX_W-1:0] REG_UNMAPPED = gds_pkg::REG_IDX_W'(6);

    localparam int     VEL_MAX = 32'h7FFF_FFFF;
    localparam int     VEL_MIN = 32'h8000_0000;
    localparam longint DIV_MAX = (64'sd1 <<< (gds_pkg::DATA_BITS - 1)) - 1;
    localparam longint DIV_MIN = -DIV_MAX - 1;

    typedef struct {
        logic signed [gds_pkg::FIELD_W-1:0] div_value;
        logic                               overflow;
        logic                               last_cell;
    } t_div_result;

    class divergence_scoreboard;
        logic [gds_pkg::SIZE_W-1:0]  size_x;
        logic [gds_pkg::SIZE_W-1:0]  size_y;
        logic [gds_pkg::PLANE_W-1:0] size_z;
        logic [gds_pkg::COEF_W-1:0]  coef_x;
        logic [gds_pkg::COEF_W-1:0]  coef_y;
        logic [gds_pkg::COEF_W-1:0]  coef_z;
        int                          vel_u [2][gds_pkg::CELLS];
        int                          vel_v [2][gds_pkg::CELLS];
        int                          vel_w [2][gds_pkg::CELLS];
        int                          w_older [gds_pkg::CELLS];
        int                          col;
        int                          row;
        int                          plane;
        t_div_result                 pending_divs [$];
        int                          mismatches;
        int                          cells_in;
        int                          results_seen;
        int                          saturated;
        int                          interior_cells;
        int                          grids_done;

        function new();
            size_x = gds_pkg::SIZE_XY_RST;
            size_y = gds_pkg::SIZE_XY_RST;
            size_z = gds_pkg::SIZE_Z_RST;
            coef_x = gds_pkg::COEF_RST;
            coef_y = gds_pkg::COEF_RST;
            coef_z = gds_pkg::COEF_RST;
            col = 0;
            row = 0;
            plane = 0;
            mismatches = 0;
            cells_in = 0;
            results_seen = 0;
            saturated = 0;
            interior_cells = 0;
            grids_done = 0;
        endfunction

        function int clamp_size(int s, int hi);
            return (s < 3) ? 3 : (s > hi) ? hi : s;
        endfunction

        function void set_reg(logic [gds_pkg::REG_IDX_W-1:0] idx,
                              logic [gds_pkg::PDATA_W-1:0] value);
            case (idx)
                gds_pkg::REG_SIZE_X: size_x = value[gds_pkg::SIZE_W-1:0];
                gds_pkg::REG_SIZE_Y: size_y = value[gds_pkg::SIZE_W-1:0];
                gds_pkg::REG_SIZE_Z: size_z = value[gds_pkg::PLANE_W-1:0];
                gds_pkg::REG_INV_DX: coef_x = value[gds_pkg::COEF_W-1:0];
                gds_pkg::REG_INV_DY: coef_y = value[gds_pkg::COEF_W-1:0];
                gds_pkg::REG_INV_DZ: coef_z = value[gds_pkg::COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function longint axis_term(int plus, int minus, logic [gds_pkg::COEF_W-1:0] coef);
            longint      diff;
            logic [65:0] prod;
            longint      scaled;
            diff = longint'(plus) - longint'(minus);
            prod = (diff < 0) ? -diff : diff;
            prod = prod * coef + (66'd1 << (gds_pkg::FRAC_BITS - 1));
            scaled = longint'(prod >> gds_pkg::FRAC_BITS);
            return (diff < 0) ? -scaled : scaled;
        endfunction

        function int cells_to_grid_end();
            int sx, sy, sz, c, r, p, n;
            sx = clamp_size(size_x, gds_pkg::MAX_X);
            sy = clamp_size(size_y, gds_pkg::MAX_Y);
            sz = clamp_size(size_z, 65535);
            c = col;
            r = row;
            p = plane;
            n = 0;
            while (1) begin
                n++;
                if (c + 1 < sx) begin
                    c++;
                end else begin
                    c = 0;
                    if (r + 1 < sy) begin
                        r++;
                    end else begin
                        r = 0;
                        if (p + 1 >= sz) return n;
                        p++;
                    end
                end
            end
        endfunction

        function void predict_divergence(int u, int v, int w);
            int          sx, sy, sz, idx, cur, prv;
            bit          end_row, end_plane, end_grid, interior;
            longint      sum;
            t_div_result r;
            sx = clamp_size(size_x, gds_pkg::MAX_X);
            sy = clamp_size(size_y, gds_pkg::MAX_Y);
            sz = clamp_size(size_z, 65535);
            idx = row * gds_pkg::MAX_X + col;
            cur = plane & 1;
            prv = cur ^ 1;
            end_row = col + 1 >= sx;
            end_plane = end_row && row + 1 >= sy;
            end_grid = end_plane && plane + 1 >= sz;
            vel_u[cur][idx] = u;
            vel_v[cur][idx] = v;
            vel_w[cur][idx] = w;
            if (plane >= 1) begin
                interior = plane >= 2 && col >= 1 && col + 1 < sx && row >= 1 && row + 1 < sy;
                sum = 0;
                r.overflow = 1'b0;
                if (interior) begin
                    sum = axis_term(vel_u[prv][idx + 1], vel_u[prv][idx - 1], coef_x)
                        + axis_term(vel_v[prv][idx + gds_pkg::MAX_X],
                                    vel_v[prv][idx - gds_pkg::MAX_X], coef_y)
                        + axis_term(vel_w[cur][idx], w_older[idx], coef_z);
                    interior_cells++;
                end
                if (sum > DIV_MAX) begin
                    sum = DIV_MAX;
                    r.overflow = 1'b1;
                end
                if (sum < DIV_MIN) begin
                    sum = DIV_MIN;
                    r.overflow = 1'b1;
                end
                r.div_value = gds_pkg::FIELD_W'(sum);
                r.last_cell = end_grid;
                w_older[idx] = vel_w[prv][idx];
                pending_divs.push_back(r);
            end
            if (end_grid) begin
                col = 0;
                row = 0;
                plane = 0;
            end else if (end_plane) begin
                col = 0;
                row = 0;
                plane++;
            end else if (end_row) begin
                col = 0;
                row++;
            end else begin
                col++;
            end
            cells_in++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic signed [gds_pkg::FIELD_W-1:0] div, logic ovf, logic last);
            t_div_result e;
            if (pending_divs.size() == 0) begin
                report_mismatch($sformatf("unexpected result div %0d ovf %0b last %0b",
                                          div, ovf, last));
                return;
            end
            e = pending_divs.pop_front();
            if (div !== e.div_value || ovf !== e.overflow || last !== e.last_cell)
                report_mismatch($sformatf("div %0d/%0d ovf %0b/%0b last %0b/%0b (got/exp)",
                                          div, e.div_value, ovf, e.overflow,
                                          last, e.last_cell));
            results_seen++;
            if (e.overflow) saturated++;
            if (e.last_cell) grids_done++;
        endtask

        function int pending();
            return pending_divs.size();
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic signed [gds_pkg::FIELD_W-1:0] i_vel_x = '0;
    logic signed [gds_pkg::FIELD_W-1:0] i_vel_y = '0;
    logic signed [gds_pkg::FIELD_W-1:0] i_vel_z = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic signed [gds_pkg::FIELD_W-1:0] o_div_value;
    logic                               o_overflow;
    logic                               o_last_cell;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [gds_pkg::ADDR_W-1:0]         paddr = '0;
    logic [gds_pkg::PDATA_W-1:0]        pwdata = '0;
    logic [gds_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;

    divergence_scoreboard sb = new();

    grid_divergence_stencil i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_vel_z     (i_vel_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_div_value (o_div_value),
        .o_overflow  (o_overflow),
        .o_last_cell (o_last_cell),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_div_value, o_overflow, o_last_cell);
            if (i_valid && !o_stall) sb.predict_divergence(i_vel_x, i_vel_y, i_vel_z);
        end
    end

    initial begin : watchdog
        int quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("grid_divergence_stencil regression: fail");
        $finish;
    end

    task automatic write_reg(input logic [gds_pkg::REG_IDX_W-1:0] idx,
                             input logic [gds_pkg::PDATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= gds_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic offer_cell(input int u, input int v, input int w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_vel_x <= u;
        i_vel_y <= v;
        i_vel_z <= w;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_velocity(int style);
        int sel;
        sel = (style == 3) ? $urandom_range(4) : style;
        case (sel)
            0: return $urandom();
            1: return int'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
            2: return int'($urandom_range(8)) - 4;
            3: return VEL_MAX;
            default: return VEL_MIN;
        endcase
    endfunction

    function automatic logic [gds_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0: return 32'hFFFF_FFFF;
            1: return 32'd1;
            2: return 32'd0;
            3: return 32'h0000_8000;
            4: return 32'h0001_0000;
            5: return $urandom();
            default: return $urandom_range(1, 32'h0003_0000);
        endcase
    endfunction

    function automatic logic [gds_pkg::PDATA_W-1:0] pick_extent(int hi, int width);
        int s;
        s = ($urandom_range(15) == 0) ? $urandom_range(2) : $urandom_range(3, hi);
        return ($urandom() << width) | gds_pkg::PDATA_W'(s);
    endfunction

    task automatic send_cells(input int n, input int style);
        repeat (n) offer_cell(pick_velocity(style), pick_velocity(style), pick_velocity(style));
        i_valid <= 1'b0;
    endtask

    task automatic shrink_episode();
        settle();
        write_reg(gds_pkg::REG_SIZE_X, 32'd64);
        write_reg(gds_pkg::REG_SIZE_Y, 32'd127);
        write_reg(gds_pkg::REG_SIZE_Z, 32'h0000_FFFF);
        send_cells(2 * gds_pkg::MAX_X + $urandom_range(gds_pkg::MAX_X - 1), 3);
        settle();
        write_reg(gds_pkg::REG_SIZE_X, $urandom_range(3, 8));
        write_reg(gds_pkg::REG_SIZE_Y, $urandom_range(3, 4));
        write_reg(gds_pkg::REG_SIZE_Z, 32'd3);
        send_cells(sb.cells_to_grid_end(), 3);
    endtask

    task automatic random_grid();
        settle();
        write_reg(gds_pkg::REG_SIZE_X, pick_extent(7, gds_pkg::SIZE_W));
        write_reg(gds_pkg::REG_SIZE_Y, pick_extent(6, gds_pkg::SIZE_W));
        write_reg(gds_pkg::REG_SIZE_Z, pick_extent(5, gds_pkg::PLANE_W));
        if ($urandom_range(1)) begin
            write_reg(gds_pkg::REG_INV_DX, pick_coef());
            write_reg(gds_pkg::REG_INV_DY, pick_coef());
            write_reg(gds_pkg::REG_INV_DZ, pick_coef());
        end
        send_cells(sb.cells_to_grid_end(), $urandom_range(3));
    endtask

    initial begin
        int base;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct <= RECV_IDLE[0];

        write_reg(REG_UNMAPPED, $urandom());
        write_reg(gds_pkg::REG_SIZE_X, 32'd0);
        write_reg(gds_pkg::REG_SIZE_Y, 32'd1);
        write_reg(gds_pkg::REG_SIZE_Z, 32'd2);
        write_reg(gds_pkg::REG_INV_DX, 32'hFFFF_FFFF);
        write_reg(gds_pkg::REG_INV_DY, 32'hFFFF_FFFF);
        write_reg(gds_pkg::REG_INV_DZ, 32'hFFFF_FFFF);
        for (int k = 0; k < 27; k++) begin
            offer_cell((k % 3 == 0) ? VEL_MIN : (k % 3 == 2) ? VEL_MAX : 0,
                       ((k / 3) % 3 == 0) ? VEL_MIN : ((k / 3) % 3 == 2) ? VEL_MAX : 1,
                       (k / 9 == 0) ? VEL_MIN : (k / 9 == 2) ? VEL_MAX : -1);
        end
        i_valid <= 1'b0;

        base = sb.cells_in;
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = SEND_IDLE[m];
            recv_idle_pct <= RECV_IDLE[m];
            if (m == 0) shrink_episode();
            if (m == 2) begin
                settle();
                hold_request <= 1'b1;
            end
            while (sb.cells_in < base + (m + 1) * RANDOM_SHARE) random_grid();
        end

        settle();
        $display("summary: %0d cells driven, %0d results checked, %0d interior, %0d saturated",
                 sb.cells_in, sb.results_seen, sb.interior_cells, sb.saturated);
        $display("summary: %0d grids closed, mid-grid shrink from 64x64, %0d-cycle output hold",
                 sb.grids_done, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("grid_divergence_stencil regression: pass");
        else
            $display("grid_divergence_stencil regression: fail");
        $finish;
    end

endmodule
